### design/spg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spg_pkg
// Shared constants and types of the steering phasor generator.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int FRAME_SIZE = 64;
    localparam int NUM_BINS   = FRAME_SIZE / 2 + 1;
    localparam int BIN_W      = $clog2(NUM_BINS);

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        logic             last;
    } t_tag;

endpackage
`default_nettype wire

### design/spg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spg_if
// Valid/ready channels of the steering phasor generator.
// ----------------------------------------------------------------------------
interface spg_dir_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

interface spg_phasor_if;
    logic               valid;
    logic               ready;
    logic [5:0]         bin;
    logic signed [15:0] phasor_real;
    logic signed [15:0] phasor_imag;
    logic               last_bin;

    modport source (output valid, output bin, output phasor_real, output phasor_imag,
                    output last_bin, input ready);
    modport sink   (input valid, input bin, input phasor_real, input phasor_imag,
                    input last_bin, output ready);
endinterface

interface spg_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] delay_gain;

    modport source (output valid, output delay_gain, input ready);
    modport sink   (input valid, input delay_gain, output ready);
endinterface
`default_nettype wire

### design/spg_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spg_sine
// Eight-stage sine of a 32-bit turn phase, Q1.15 out, at most one multiply per stage.
// ----------------------------------------------------------------------------
module spg_sine import spg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_tag               i_tag,
    input  logic [31:0]        i_phase,
    output t_tag               o_tag,
    output logic signed [15:0] o_sine
);

    localparam int STAGES = 8;

    localparam logic signed [31:0] C0 = 32'sd1686629713;
    localparam logic signed [31:0] C1 = -32'sd693598668;
    localparam logic signed [31:0] C2 = 32'sd85569306;
    localparam logic signed [31:0] C3 = -32'sd5026995;
    localparam logic signed [31:0] C4 = 32'sd172272;

    localparam logic [30:0]        Q30_ONE = 31'h4000_0000;
    localparam logic signed [63:0] TZ_BIAS = 64'sd1073741823;

    // product scaled by 2^-30, truncated toward zero
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic [30:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'($signed({1'b0, b}));
        p = p + (p[63] ? TZ_BIAS : 64'sd0);
        return p[61:30];
    endfunction

    logic               r_v   [STAGES];
    t_tag               r_tag [STAGES];
    logic               r_neg [STAGES-1];
    logic [30:0]        r_x   [6];
    logic [30:0]        r_x2  [1:4];
    logic signed [31:0] r_a   [2:6];
    logic signed [15:0] r_out;

    logic [30:0]        w_x;
    logic [61:0]        w_xx;
    logic [32:0]        w_rnd;
    logic [14:0]        w_mag;

    // fold into the first quarter
    assign w_x  = i_phase[30] ? (Q30_ONE - {1'b0, i_phase[29:0]}) : {1'b0, i_phase[29:0]};
    assign w_xx = 62'(r_x[0]) * 62'(r_x[0]);

    // round to q15 and clamp
    always_comb begin
        w_rnd = 33'($unsigned(r_a[6])) + 33'd16384;
        if (r_a[6][31]) begin
            w_mag = 15'd0;
        end else if (w_rnd[32:15] > 18'd32767) begin
            w_mag = 15'h7fff;
        end else begin
            w_mag = w_rnd[29:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_tag.valid;
            for (int i = 1; i < STAGES; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            r_neg[0] <= i_phase[31];
            for (int i = 1; i < STAGES - 1; i++) begin
                r_neg[i] <= r_neg[i-1];
            end
            r_x[0] <= w_x;
            for (int i = 1; i < 6; i++) begin
                r_x[i] <= r_x[i-1];
            end
            r_x2[1] <= w_xx[60:30];
            r_x2[2] <= r_x2[1];
            r_x2[3] <= r_x2[2];
            r_x2[4] <= r_x2[3];
            r_a[2]  <= C3 + mul_q30(C4, r_x2[1]);
            r_a[3]  <= C2 + mul_q30(r_a[2], r_x2[2]);
            r_a[4]  <= C1 + mul_q30(r_a[3], r_x2[3]);
            r_a[5]  <= C0 + mul_q30(r_a[4], r_x2[4]);
            r_a[6]  <= mul_q30(r_a[5], r_x[5]);
            r_out   <= r_neg[6] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    always_comb begin
        o_tag       = r_tag[STAGES-1];
        o_tag.valid = r_v[STAGES-1];
    end
    assign o_sine = r_out;

endmodule
`default_nettype wire

### design/steering_phasor_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steering_phasor_generator
// Angle in, NUM_BINS phasor words out (33 at a 64-sample frame).
// Each angle passes the turns, direction-sine and step stages; the bin sequencer
// then issues one bin per cycle into the cosine and sine pipelines while the
// sink is ready, one word each, and starts the next angle's step at the last bin.
// Synchronous active-low reset empties all pipelines; delay_gain resets to 1193.
// ----------------------------------------------------------------------------
module steering_phasor_generator import spg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spg_dir_if.sink       i_dir,
    spg_phasor_if.source  o_phasor,
    spg_cfg_if.sink       i_cfg
);

    localparam logic [15:0]        DELAY_GAIN_RESET = 16'd1193;
    localparam logic signed [34:0] DIR_TO_TURNS     = 35'sd5468522204;
    localparam logic [31:0]        QUARTER_TURN     = 32'h4000_0000;

    logic [15:0]        r_delay_gain;

    logic               w_en;
    logic               w_front_en;
    logic               w_seq_take;
    logic               w_at_last;

    logic signed [49:0] w_prod;
    logic               r_a_valid;
    logic [47:0]        r_a_prod;
    logic [47:0]        w_turns_sum;
    logic               r_b_valid;
    logic [31:0]        r_b_turns;

    t_tag               w_ds_tag;
    logic signed [15:0] w_ds;
    logic [14:0]        w_abs_s;
    logic               r_c_valid;
    logic               r_c_pos;
    logic [30:0]        r_c_mag;
    logic [40:0]        w_scaled;
    logic [40:0]        w_q;
    logic               r_d_valid;
    logic [31:0]        r_d_step;

    logic               r_busy;
    logic [31:0]        r_step;
    logic [31:0]        r_acc;
    logic [BIN_W-1:0]   r_bin;

    t_tag               w_iss_tag;
    t_tag               w_sin_tag;
    t_tag               w_cos_tag;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;

    // handshake
    assign w_en       = !w_sin_tag.valid || o_phasor.ready;
    assign w_at_last  = (r_bin == BIN_W'(NUM_BINS - 1));
    assign w_seq_take = w_en && (!r_busy || w_at_last);
    assign w_front_en = !r_d_valid || w_seq_take;

    assign i_dir.ready = w_front_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_gain <= DELAY_GAIN_RESET;
        end else if (i_cfg.valid) begin
            r_delay_gain <= i_cfg.delay_gain;
        end
    end

    // angle to turns, sine of angle, step per bin
    assign w_prod      = i_dir.direction * DIR_TO_TURNS;
    assign w_turns_sum = r_a_prod + 48'd32768;
    assign w_abs_s     = w_ds[15] ? 15'(-w_ds) : w_ds[14:0];
    assign w_scaled    = {1'b0, r_c_mag, 9'b0} + 41'(FRAME_SIZE / 2);
    assign w_q         = w_scaled / 41'(FRAME_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (w_front_en) begin
            r_a_valid <= i_dir.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= w_ds_tag.valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_front_en) begin
            r_a_prod  <= w_prod[47:0];
            r_b_turns <= w_turns_sum[47:16];
            r_c_pos   <= !w_ds[15];
            r_c_mag   <= 31'(r_delay_gain) * 31'(w_abs_s);
            r_d_step  <= r_c_pos ? (32'd0 - w_q[31:0]) : w_q[31:0];
        end
    end

    spg_sine u_dir_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_front_en),
        .i_tag   ('{valid: r_b_valid, bin: '0, last: 1'b0}),
        .i_phase (r_b_turns),
        .o_tag   (w_ds_tag),
        .o_sine  (w_ds)
    );

    // bin sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bin  <= '0;
        end else if (w_seq_take) begin
            r_busy <= r_d_valid;
            r_bin  <= '0;
        end else if (w_en && r_busy) begin
            r_bin  <= r_bin + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq_take && r_d_valid) begin
            r_step <= r_d_step;
            r_acc  <= '0;
        end else if (w_en && r_busy) begin
            r_acc  <= r_acc + r_step;
        end
    end

    assign w_iss_tag = '{valid: r_busy, bin: r_bin, last: w_at_last};

    spg_sine u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_iss_tag),
        .i_phase (r_acc),
        .o_tag   (w_sin_tag),
        .o_sine  (w_sin)
    );

    spg_sine u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_iss_tag),
        .i_phase (r_acc + QUARTER_TURN),
        .o_tag   (w_cos_tag),
        .o_sine  (w_cos)
    );

    assign o_phasor.valid       = w_sin_tag.valid;
    assign o_phasor.bin         = 6'(w_sin_tag.bin);
    assign o_phasor.phasor_real = w_cos;
    assign o_phasor.phasor_imag = w_sin;
    assign o_phasor.last_bin    = w_sin_tag.last;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cos_tag.valid == w_sin_tag.valid) &&
        (!w_sin_tag.valid || (w_cos_tag.bin == w_sin_tag.bin &&
                              w_cos_tag.last == w_sin_tag.last)))
        else $error("cosine and sine lanes out of step");

    a_bin_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_busy && !w_at_last) |=>
        (r_busy && r_bin == BIN_W'($past(r_bin) + 1'b1)))
        else $error("bin counter skipped");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_busy && w_at_last && !r_d_valid) |=> !r_busy)
        else $error("sequencer kept running past last bin");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && !w_seq_take) |=> (r_d_valid && $stable(r_d_step)))
        else $error("pending phase step lost while sequencer busy");

endmodule
`default_nettype wire

### test/tb_steering_phasor_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_steering_phasor_generator
// Sends angles through the direction channel in random bursts and compares
// every phasor word against an in-bench fixed-point predictor, which covers
// the angle to turns conversion, the polynomial sine and the per-bin phase
// accumulation. The delay gain changes between phases while the block is idle,
// and the phasor sink stalls on a pattern that changes over the run.
// ----------------------------------------------------------------------------
module tb_steering_phasor_generator;
    import spg_pkg::*;

    typedef struct {
        logic [5:0]         bin;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } phasor_word_t;

    class phasor_scoreboard;
        logic [15:0]  gain;
        phasor_word_t expected_words[$];
        int           errors;

        function new();
            gain   = 16'd1193;
            errors = 0;
        endfunction

        function automatic longint trunc_q30(longint v);
            if (v >= 0) return v >>> 30;
            return -((-v) >>> 30);
        endfunction

        // sin(pi/2 * x), x in q30 over one quarter, result q15 in [0, 32767]
        function automatic logic signed [15:0] quarter_wave(longint x);
            longint x2;
            longint acc;
            x2  = trunc_q30(x * x);
            acc = 172272;
            acc = -5026995 + trunc_q30(acc * x2);
            acc = 85569306 + trunc_q30(acc * x2);
            acc = -693598668 + trunc_q30(acc * x2);
            acc = 1686629713 + trunc_q30(acc * x2);
            acc = trunc_q30(acc * x);
            if (acc < 0) acc = 0;
            acc = (acc + 16384) >>> 15;
            if (acc > 32767) acc = 32767;
            return acc[15:0];
        endfunction

        function automatic logic signed [15:0] sine_of_turns(logic [31:0] p);
            longint             pos;
            logic signed [15:0] mag;
            pos = p[29:0];
            if (p[30]) pos = 64'sd1073741824 - pos;
            mag = quarter_wave(pos);
            return p[31] ? -mag : mag;
        endfunction

        function automatic void note_direction(logic signed [15:0] d);
            longint             prod;
            longint             mag;
            longint             abs_s;
            longint             quot;
            logic [31:0]        step;
            logic [31:0]        phase;
            logic signed [15:0] s;
            phasor_word_t       w;
            prod  = longint'(d) * 64'sd5468522204 + 64'sd32768;
            s     = sine_of_turns(prod[47:16]);
            abs_s = (s < 0) ? -s : s;
            mag   = longint'(gain) * abs_s * 512;
            quot  = (mag + FRAME_SIZE / 2) / FRAME_SIZE;
            step  = (s >= 0) ? (32'd0 - quot[31:0]) : quot[31:0];
            phase = 32'd0;
            for (int k = 0; k < NUM_BINS; k++) begin
                w.bin  = k[5:0];
                w.re   = sine_of_turns(phase + 32'h4000_0000);
                w.im   = sine_of_turns(phase);
                w.last = (k == NUM_BINS - 1);
                expected_words.push_back(w);
                phase += step;
            end
        endfunction

        function automatic void check_word(logic [5:0] bin, logic signed [15:0] re,
                                           logic signed [15:0] im, logic last);
            phasor_word_t w;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual bin %0d re %0d im %0d",
                         $time, bin, re, im);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (bin !== w.bin) begin
                $display("%0t: bin mismatch, expected %0d actual %0d", $time, w.bin, bin);
                errors++;
            end
            if (re !== w.re) begin
                $display("%0t: real mismatch at bin %0d, expected %0d actual %0d",
                         $time, w.bin, w.re, re);
                errors++;
            end
            if (im !== w.im) begin
                $display("%0t: imag mismatch at bin %0d, expected %0d actual %0d",
                         $time, w.bin, w.im, im);
                errors++;
            end
            if (last !== w.last) begin
                $display("%0t: last_bin mismatch at bin %0d, expected %0d actual %0d",
                         $time, w.bin, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    spg_dir_if    dir_ch();
    spg_phasor_if phasor_ch();
    spg_cfg_if    cfg_ch();

    steering_phasor_generator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (dir_ch),
        .o_phasor (phasor_ch),
        .i_cfg    (cfg_ch)
    );

    phasor_scoreboard sb;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_800_000;
        $display("Simulation FAILED");
        $finish;
    end

    // phasor sink with a stall pattern that changes mode over the run
    initial begin
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left  = 0;
        phasor_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (phasor_ch.valid && phasor_ch.ready)
                    sb.check_word(phasor_ch.bin, phasor_ch.phasor_real,
                                  phasor_ch.phasor_imag, phasor_ch.last_bin);
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 400);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: phasor_ch.ready <= 1'b1;
                    1: phasor_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: phasor_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: phasor_ch.ready <= ((mode_left % 11) < 6);
                endcase
            end
        end
    end

    task automatic send_direction(input logic signed [15:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 50);
            if (gap > 0) begin
                dir_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        dir_ch.valid     <= 1'b1;
        dir_ch.direction <= d;
        do @(posedge i_clk); while (!dir_ch.ready);
        sb.note_direction(d);
        burst_left--;
    endtask

    task automatic wait_until_drained();
        dir_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_delay_gain(input logic [15:0] g);
        wait_until_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.delay_gain <= g;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.gain = g;
    endtask

    function automatic logic signed [15:0] pick_direction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 16'(int'($urandom_range(0, 51472)) - 25736);
        if (r < 95) return 16'($urandom);
        case ($urandom_range(0, 4))
            0: return 16'sd25736;
            1: return -16'sd25736;
            2: return 16'sd12868;
            3: return -16'sd12868;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) wait_until_drained();
            send_direction(pick_direction());
        end
    endtask

    initial begin
        sb = new();
        burst_left = 0;
        i_rst_n              <= 1'b0;
        dir_ch.valid         <= 1'b0;
        dir_ch.direction     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.delay_gain    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gain: range edges, quarter and eighth turns, bit patterns
        send_direction(16'sd0);
        send_direction(16'sd25736);
        send_direction(-16'sd25736);
        send_direction(16'sd12868);
        send_direction(-16'sd12868);
        send_direction(16'sd6434);
        send_direction(-16'sd6434);
        send_direction(16'sd1);
        send_direction(-16'sd1);
        send_direction(16'sd32767);
        send_direction(-16'sd32768);
        send_direction(16'sh5555);
        send_direction(16'shAAAA);

        // largest gain: deepest phase steps and wrap
        write_delay_gain(16'hFFFF);
        send_direction(16'sd12868);
        send_direction(-16'sd12868);
        send_direction(16'sd25736);
        send_direction(16'sd3217);
        send_direction(-16'sd32768);

        // zero gain: every phasor sits at one
        write_delay_gain(16'h0000);
        send_direction(16'sd12868);
        send_direction(-16'sd1);

        write_delay_gain(16'd1);
        run_random(35, -1);
        write_delay_gain(16'($urandom_range(0, 65535)));
        run_random(35, 15);
        write_delay_gain(16'hFFFF);
        run_random(35, -1);
        write_delay_gain(16'h0000);
        run_random(30, -1);
        write_delay_gain(16'($urandom_range(0, 65535)));
        run_random(40, 20);
        write_delay_gain(16'd1193);
        run_random(35, -1);

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
